// ----- rtl/audio_stutter_looper_core_defines.svh -----
// assertion macros shared by the stutter looper rtl
`ifndef AUDIO_STUTTER_LOOPER_CORE_DEFINES_SVH
`define AUDIO_STUTTER_LOOPER_CORE_DEFINES_SVH

// same-cycle implication
`define ASL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/asl_pkg.sv -----
// types and constants of the stutter looper
package asl_pkg;

    localparam int CHANNELS       = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_BITS      = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLICE_LEN     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SLICE_LEN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_COUNT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_IN_LEN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_OUT_LEN  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERRUPT_LEN = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_LEN   = 3'd6;

    // end event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_MANUAL  = 2'd1;
    localparam logic [1:0] EV_NATURAL = 2'd2;
    localparam logic [1:0] EV_RESTART = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_0;
        t_sample sample_1;
        logic    start_request;
        logic    stop_request;
    } t_in_beat;

    typedef struct packed {
        t_sample    out_0;
        t_sample    out_1;
        logic [1:0] end_event;
        logic       is_playing;
    } t_out_beat;

    typedef struct packed {
        logic signed [8:0] loops;
        logic [16:0]       stop_len;
        logic [15:0]       fi_work;
        logic [15:0]       fo_work;
        logic [15:0]       int_work;
        logic [15:0]       rel_work;
    } t_slice;

endpackage

// ----- rtl/audio_stutter_looper_core.sv -----
// stutter looper core: live fade-out, slice record, looped playback, release
//
// input channel (i_in_valid / o_in_ready): one audio frame per beat, with
// start and stop request flags applied before the frame is processed.
// output channel (o_out_valid / i_out_ready): one result beat per frame,
// processed samples, end event and the playback flag.
// config channel (i_cfg_valid / o_cfg_ready): register index and data,
// always ready; write only while no frame is in flight.
// from input beat to result beat a frame goes through a record
// write, three ramp gains (release, interrupt, loop fade) each set up in the
// job step and, unless trivial, computed by a shared 16-step restoring divider,
// then the multiply steps S_MUL1 and S_MUL2 per channel and a final control update.
// one frame is in flight at a time; the next beat is taken while the last
// result still sits in the output register.
// a stalled receiver holds the result register; the next frame then waits
// at its last step until the register frees up.
// reset clears all control state and loads the register defaults; the
// loop buffer needs no clearing as entries are always recorded before play.
`include "audio_stutter_looper_core_defines.svh"

module audio_stutter_looper_core #(
    parameter int BUFFER_FRAMES = 32768
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  asl_pkg::t_in_beat                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output asl_pkg::t_out_beat                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [asl_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [asl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import asl_pkg::*;

    localparam int AW  = (BUFFER_FRAMES > 1) ? $clog2(BUFFER_FRAMES) : 1;
    localparam int RPW = $clog2(BUFFER_FRAMES + 1);
    localparam int ROW = CHANNELS * SAMPLE_BITS;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] JOB_REL  = 2'd0;
    localparam logic [1:0] JOB_INT  = 2'd1;
    localparam logic [1:0] JOB_FADE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_JOB, S_DIV, S_MUL1, S_MUL2, S_END
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0]       r_cfg_slice_len;
    logic [12:0]       r_cfg_min_slice;
    logic signed [8:0] r_cfg_loop_count;
    logic [15:0]       r_cfg_fade_in;
    logic [15:0]       r_cfg_fade_out;
    logic [15:0]       r_cfg_interrupt;
    logic [15:0]       r_cfg_release;

    // looper state
    logic              r_rec_active;
    logic [RPW-1:0]    r_rec_pos;
    logic              r_play_active;
    logic              r_play_pending;
    logic [17:0]       r_play_pos;
    logic signed [8:0] r_loop_index;
    logic signed [8:0] r_loops;
    logic              r_int_active;
    logic [15:0]       r_int_pos;
    logic              r_rel_active;
    logic [15:0]       r_rel_pos;
    logic              r_stop_pending;
    logic [16:0]       r_stop_len;
    logic [15:0]       r_fi_work;
    logic [15:0]       r_fo_work;
    logic [15:0]       r_int_work;
    logic [15:0]       r_rel_work;

    // per-frame working registers
    t_sample              r_live [CHANNELS];
    t_sample              r_outs [CHANNELS];
    logic [GAIN_BITS-1:0] r_gain [3];
    logic [1:0]           r_job;
    logic [CHW-1:0]       r_ch;
    logic [15:0]          r_rem;
    logic [15:0]          r_den;
    logic [15:0]          r_quo;
    logic [3:0]           r_cnt;
    logic                 r_inv;
    logic signed [41:0]   r_p1;
    logic                 r_out_valid;
    t_out_beat            r_out;

    // loop buffer, one row per frame
    logic [ROW-1:0] r_mem [BUFFER_FRAMES];
    logic [ROW-1:0] r_mem_q;
    logic           mem_we;
    logic [ROW-1:0] mem_wdata;

    t_slice slice_cfg;

    function automatic t_slice slice_setup(
        input logic [15:0]       sl,
        input logic [12:0]       ml,
        input logic signed [8:0] lc,
        input logic [15:0]       fi,
        input logic [15:0]       fo,
        input logic [15:0]       il,
        input logic [15:0]       rl
    );
        logic [15:0] slice;
        logic [15:0] half;
        logic [15:0] fiw;
        logic [15:0] fow;
        logic [15:0] iw;
        logic [15:0] rw;
        t_slice      s;
        slice = (sl == 16'd0) ? 16'd1 : sl;
        if ({3'b000, ml} > slice) begin
            slice = {3'b000, ml};
        end
        fiw  = (fi == 16'd0) ? 16'd1 : fi;
        fow  = (fo == 16'd0) ? 16'd1 : fo;
        iw   = (il == 16'd0) ? 16'd1 : il;
        rw   = (rl == 16'd0) ? 16'd1 : rl;
        half = slice >> 1;
        // ramps that do not fit the slice share it
        if ((17'(fiw) + 17'(fow)) >= 17'(slice)) begin
            if (fiw < half) begin
                fow = slice - fiw;
            end else if (fow < half) begin
                fiw = slice - fow;
            end else begin
                fiw = half;
                fow = half;
            end
        end
        if (iw > (slice - fiw)) begin
            iw = slice - fiw;
        end
        s.loops    = lc;
        s.stop_len = {1'b0, slice};
        s.fi_work  = fiw;
        s.fo_work  = fow;
        s.int_work = iw;
        s.rel_work = rw;
        return s;
    endfunction

    assign slice_cfg = slice_setup(r_cfg_slice_len, r_cfg_min_slice, r_cfg_loop_count,
                                   r_cfg_fade_in, r_cfg_fade_out, r_cfg_interrupt,
                                   r_cfg_release);

    // handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // stop request: end the loop one fade-out after the current position
    logic [18:0] stop_cand;
    assign stop_cand = 19'(r_play_pos) + 19'(r_fo_work);

    // recording
    logic rec_in_range;
    assign rec_in_range = (32'(r_rec_pos) < 32'(BUFFER_FRAMES));
    assign mem_we       = (r_state == S_PREP) && r_rec_active && rec_in_range;
    assign mem_wdata    = {r_live[1], r_live[0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_rec_pos)] <= mem_wdata;
        end else begin
            r_mem_q <= r_mem[AW'(r_play_pos)];
        end
    end

    // ramp job set-up
    logic                 j_take;
    logic                 j_direct;
    logic                 j_inv;
    logic [15:0]          j_n;
    logic [15:0]          j_d;
    logic [GAIN_BITS-1:0] j_gain;

    always_comb begin
        j_take   = 1'b0;
        j_direct = 1'b1;
        j_inv    = 1'b0;
        j_n      = '0;
        j_d      = '0;
        j_gain   = GAIN_ONE;
        case (r_job)
            JOB_REL: begin
                if (r_rel_active && (r_rel_pos < r_rel_work)) begin
                    j_take   = 1'b1;
                    j_direct = 1'b0;
                    j_n      = r_rel_pos;
                    j_d      = r_rel_work - 16'd1;
                end
            end
            JOB_INT: begin
                if (r_int_active && (r_int_pos < r_int_work)) begin
                    j_take = 1'b1;
                    if (r_int_work != 16'd1) begin
                        j_direct = 1'b0;
                        j_inv    = 1'b1;
                        j_n      = r_int_pos;
                        j_d      = r_int_work - 16'd1;
                    end
                end
            end
            JOB_FADE: begin
                if (18'(r_fi_work) > r_play_pos) begin
                    j_direct = 1'b0;
                    j_n      = r_play_pos[15:0];
                    j_d      = r_fi_work;
                end else if (stop_cand > 19'(r_stop_len)) begin
                    if (r_play_pos > 18'(r_stop_len)) begin
                        j_gain = '0;
                    end else begin
                        j_direct = 1'b0;
                        j_n      = 16'(18'(r_stop_len) - r_play_pos);
                        j_d      = r_fo_work;
                    end
                end
            end
            default: begin
            end
        endcase
        // ramp at or past its end, or of zero length
        if (!j_direct && ((j_d == 16'd0) || (j_n >= j_d))) begin
            j_direct = 1'b1;
            j_gain   = j_inv ? '0 : GAIN_ONE;
        end
    end

    // restoring divider step: gain = n * 2^16 / d, n < d
    logic [16:0] div_rem2;
    logic        div_ge;
    logic [15:0] div_q_next;
    logic [15:0] div_rem_next;

    assign div_rem2     = {r_rem, 1'b0};
    assign div_ge       = (div_rem2 >= {1'b0, r_den});
    assign div_q_next   = {r_quo[14:0], div_ge};
    assign div_rem_next = div_ge ? 16'(div_rem2 - {1'b0, r_den}) : div_rem2[15:0];

    // sample scaling
    logic                 sel_live;
    logic                 in_buf;
    t_sample              mul_s;
    logic [GAIN_BITS-1:0] ga;
    logic [GAIN_BITS-1:0] gb;
    logic signed [41:0]   mul1;
    logic signed [59:0]   mul2;

    assign sel_live = !r_play_active || (r_int_active && (r_loop_index == -9'sd1));
    assign in_buf   = (32'(r_play_pos) < 32'(BUFFER_FRAMES));
    assign mul_s    = sel_live ? r_live[r_ch]
                    : (in_buf ? $signed(r_mem_q[r_ch*SAMPLE_BITS +: SAMPLE_BITS]) : '0);
    assign ga       = sel_live ? r_gain[JOB_REL] : r_gain[JOB_INT];
    assign gb       = sel_live ? r_gain[JOB_INT] : r_gain[JOB_FADE];
    assign mul1     = mul_s * $signed({1'b0, ga});
    assign mul2     = r_p1 * $signed({1'b0, gb});

    // end-of-frame control update
    logic              e_play_active;
    logic              e_play_pending;
    logic              e_stop_pending;
    logic              e_rel_active;
    logic [15:0]       e_rel_pos;
    logic [17:0]       e_play_pos;
    logic signed [8:0] e_loop_index;
    logic              e_int_active;
    logic [15:0]       e_int_pos;
    logic              e_rec_active;
    logic [RPW-1:0]    e_rec_pos;
    logic [1:0]        e_event;
    logic              e_do_setup;
    logic signed [9:0] loops_m1;

    assign loops_m1 = $signed({r_loops[8], r_loops}) - 10'sd1;

    always_comb begin
        e_play_active  = r_play_active;
        e_play_pending = r_play_pending;
        e_stop_pending = r_stop_pending;
        e_rel_active   = r_rel_active;
        e_rel_pos      = r_rel_pos;
        e_play_pos     = r_play_pos;
        e_loop_index   = r_loop_index;
        e_int_active   = r_int_active;
        e_int_pos      = r_int_pos;
        e_rec_active   = r_rec_active;
        e_rec_pos      = r_rec_pos;
        e_event        = EV_NONE;
        e_do_setup     = 1'b0;
        // past the slice end: stop, loop again or finish
        if (r_play_active && !r_int_active && (r_play_pos > 18'(r_stop_len))) begin
            if (r_stop_pending) begin
                e_stop_pending = 1'b0;
                e_play_active  = 1'b0;
                e_play_pending = 1'b0;
                e_rel_active   = 1'b1;
                e_rel_pos      = '0;
                e_event        = EV_MANUAL;
            end else if ((r_loops < 0) ||
                         ($signed({r_loop_index[8], r_loop_index}) < loops_m1)) begin
                e_play_pos = '0;
                if (r_loop_index != 9'sd255) begin
                    e_loop_index = r_loop_index + 9'sd1;
                end
                e_do_setup = 1'b1;
                e_event    = EV_RESTART;
            end else begin
                e_play_active  = 1'b0;
                e_play_pending = 1'b0;
                e_rel_active   = 1'b1;
                e_rel_pos      = '0;
                e_event        = EV_NATURAL;
            end
        end
        if (e_play_active) begin
            e_play_pos = e_play_pos + 18'd1;
        end
        if (!r_int_active && e_play_pending) begin
            e_do_setup     = 1'b1;
            e_play_active  = 1'b1;
            e_play_pending = 1'b0;
        end
        // live fade-out done: start recording the slice
        if (r_int_active && (r_int_pos >= r_int_work)) begin
            e_int_active = 1'b0;
            e_int_pos    = '0;
            e_rec_active = 1'b1;
            e_rec_pos    = '0;
            e_loop_index = '0;
            e_play_pos   = '0;
            e_do_setup   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_cfg_slice_len  <= 16'd4800;
            r_cfg_min_slice  <= 13'd64;
            r_cfg_loop_count <= -9'sd1;
            r_cfg_fade_in    <= 16'd48;
            r_cfg_fade_out   <= 16'd48;
            r_cfg_interrupt  <= 16'd48;
            r_cfg_release    <= 16'd48;
            r_rec_active     <= 1'b0;
            r_rec_pos        <= '0;
            r_play_active    <= 1'b0;
            r_play_pending   <= 1'b0;
            r_play_pos       <= '0;
            r_loop_index     <= '0;
            r_loops          <= '0;
            r_int_active     <= 1'b0;
            r_int_pos        <= '0;
            r_rel_active     <= 1'b0;
            r_rel_pos        <= '0;
            r_stop_pending   <= 1'b0;
            r_stop_len       <= '0;
            r_fi_work        <= '0;
            r_fo_work        <= '0;
            r_int_work       <= '0;
            r_rel_work       <= '0;
            r_job            <= JOB_REL;
            r_ch             <= '0;
            r_cnt            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SLICE_LEN:     r_cfg_slice_len  <= i_cfg_data;
                    REG_MIN_SLICE_LEN: r_cfg_min_slice  <= i_cfg_data[12:0];
                    REG_LOOP_COUNT:    r_cfg_loop_count <= $signed(i_cfg_data[8:0]);
                    REG_FADE_IN_LEN:   r_cfg_fade_in    <= i_cfg_data;
                    REG_FADE_OUT_LEN:  r_cfg_fade_out   <= i_cfg_data;
                    REG_INTERRUPT_LEN: r_cfg_interrupt  <= i_cfg_data;
                    REG_RELEASE_LEN:   r_cfg_release    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // result taken; the last step reloads it in the same cycle
            if (r_out_valid && i_out_ready && (r_state != S_END)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_live[0] <= i_in.sample_0;
                        r_live[1] <= i_in.sample_1;
                        // start first, then stop
                        if (i_in.start_request && !r_int_active) begin
                            r_int_active   <= 1'b1;
                            r_int_pos      <= '0;
                            r_play_pending <= 1'b1;
                            if (!r_play_active) begin
                                r_play_active <= 1'b1;
                                r_loop_index  <= -9'sd1;
                            end
                        end
                        if (i_in.stop_request) begin
                            r_stop_pending <= 1'b1;
                            if (stop_cand < 19'(r_stop_len)) begin
                                r_stop_len <= 17'(stop_cand);
                            end
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_rec_active) begin
                        if (rec_in_range) begin
                            r_rec_pos <= r_rec_pos + 1'b1;
                        end else begin
                            r_rec_active <= 1'b0;
                        end
                    end
                    r_job   <= JOB_REL;
                    r_state <= S_JOB;
                end
                S_JOB: begin
                    if (r_job == JOB_REL) begin
                        if (j_take) begin
                            r_rel_pos <= r_rel_pos + 16'd1;
                        end else begin
                            r_rel_active <= 1'b0;
                        end
                    end
                    if ((r_job == JOB_INT) && j_take) begin
                        r_int_pos <= r_int_pos + 16'd1;
                    end
                    if (j_direct) begin
                        r_gain[r_job] <= j_gain;
                        if (r_job == JOB_FADE) begin
                            r_ch    <= '0;
                            r_state <= S_MUL1;
                        end else begin
                            r_job <= r_job + 2'd1;
                        end
                    end else begin
                        r_rem   <= j_n;
                        r_den   <= j_d;
                        r_quo   <= '0;
                        r_inv   <= j_inv;
                        r_cnt   <= 4'd15;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_rem_next;
                    r_quo <= div_q_next;
                    if (r_cnt == 4'd0) begin
                        r_gain[r_job] <= r_inv ? (GAIN_ONE - {1'b0, div_q_next})
                                               : {1'b0, div_q_next};
                        if (r_job == JOB_FADE) begin
                            r_ch    <= '0;
                            r_state <= S_MUL1;
                        end else begin
                            r_job   <= r_job + 2'd1;
                            r_state <= S_JOB;
                        end
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                S_MUL1: begin
                    r_p1    <= mul1;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // floor of s * g1 * g2 / 2^32
                    r_outs[r_ch] <= mul2[32 +: SAMPLE_BITS];
                    if (r_ch == CHW'(CHANNELS - 1)) begin
                        r_state <= S_END;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_MUL1;
                    end
                end
                S_END: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_play_active  <= e_play_active;
                        r_play_pending <= e_play_pending;
                        r_stop_pending <= e_stop_pending;
                        r_rel_active   <= e_rel_active;
                        r_rel_pos      <= e_rel_pos;
                        r_play_pos     <= e_play_pos;
                        r_loop_index   <= e_loop_index;
                        r_int_active   <= e_int_active;
                        r_int_pos      <= e_int_pos;
                        r_rec_active   <= e_rec_active;
                        r_rec_pos      <= e_rec_pos;
                        if (e_do_setup) begin
                            r_loops    <= slice_cfg.loops;
                            r_stop_len <= slice_cfg.stop_len;
                            r_fi_work  <= slice_cfg.fi_work;
                            r_fo_work  <= slice_cfg.fo_work;
                            r_int_work <= slice_cfg.int_work;
                            r_rel_work <= slice_cfg.rel_work;
                        end
                        r_out.out_0      <= r_outs[0];
                        r_out.out_1      <= r_outs[1];
                        r_out.end_event  <= e_event;
                        r_out.is_playing <= e_play_active;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASL_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_den,
                    "divider remainder reached divisor")
    `ASL_ASSERT_IMP(a_pending_play, i_clk, i_rst_n, r_play_pending, r_play_active,
                    "playback pending without active playback")
    `ASL_ASSERT_NXT(a_one_frame, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready,
                    "second frame taken while one in flight")

endmodule
